FILE: hw/rtl/ipfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_pkg: shared types and constants of the fragment reassembly tracker
// request/response payloads, controller states, datapath commands and status
// ----------------------------------------------------------------------------
package ipfr_pkg;

  // defaults for the top-level parameters
  localparam int unsigned SlotsDef      = 8;
  localparam int unsigned HolesDef      = 8;
  localparam int unsigned MaxPayloadDef = 65536;

  // hole bounds reach at most 2^16; positions are one bit wider than the size field
  localparam int unsigned PosW     = 18;
  localparam int unsigned SizeW    = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_MAX_AGE      = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_IN_USE = 1'd1;

  localparam logic [31:0] MaxAgeRst     = 32'd1000000;
  localparam logic [3:0]  SlotsInUseRst = 4'd8;
  localparam logic [15:0] HdrBytes      = 16'd20;

  typedef enum logic [1:0] {
    ST_UNFRAG   = 2'd0,
    ST_PENDING  = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_REJECT   = 2'd3
  } frag_status_e;

  typedef struct packed {
    logic [47:0] arrival_usec;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic        more_fragments;
    logic [12:0] frag_offset_units;
    logic [15:0] total_length;
  } frag_req_t;

  typedef struct packed {
    frag_status_e status;
    logic [2:0]   slot;
    logic [15:0]  place_offset;
    logic [15:0]  place_length;
    logic [16:0]  total_size;
  } frag_rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RELEASE,
    CMD_CHECK,
    CMD_EVICT,
    CMD_SEARCH,
    CMD_ALLOC,
    CMD_HOLE_READ,
    CMD_HOLE_PROC,
    CMD_HOLE_SPLIT,
    CMD_COMMIT,
    CMD_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic early_exit;
    logic evict_need;
    logic search_end;
    logic search_match;
    logic no_free;
    logic hole_more;
    logic hole_split;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RELEASE,
    S_CHECK,
    S_EVICT,
    S_SEARCH,
    S_ALLOC,
    S_HOLE_READ,
    S_HOLE_PROC,
    S_HOLE_SPLIT,
    S_COMMIT,
    S_FINISH
  } ctrl_state_e;

endpackage

FILE: hw/rtl/ip_fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_tracker: IPv4 fragment bookkeeping with hole lists
// matches fragments to pending datagrams and reports payload placement
// ----------------------------------------------------------------------------
// usage
//   in channel: one IPv4 header request per packet (in_valid_i/in_ready_o)
//   out channel: one response per request (out_valid_o/out_ready_i) with
//     status, slot, byte placement and total size on completion
//   cfg port: cfg_we_i writes max_age_usec (index 0) or slots_in_use (index 1)
//     from cfg_data_i; the user writes only while the block is idle, unchecked
// sequencing
//   one request at a time; a short, unfragmented or oversized request goes
//   from release and check straight to the output register; a fragment's
//   time is set by eviction and the slot search (one drop or one slot a
//   cycle, SLOTS in all) and the hole walk (read and update per hole, one
//   more state for a split)
// reset
//   all slots empty, no pending release, registers at their defaults
// stall
//   the response sits in an output register; the next request is taken
//   while it waits, and its result is held back until the register frees
// ----------------------------------------------------------------------------
module ip_fragment_reassembly_tracker #(
  parameter int unsigned SLOTS       = ipfr_pkg::SlotsDef,
  parameter int unsigned HOLES       = ipfr_pkg::HolesDef,
  parameter int unsigned MAX_PAYLOAD = ipfr_pkg::MaxPayloadDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ipfr_pkg::frag_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ipfr_pkg::frag_rsp_t           out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [ipfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipfr_pkg::CfgDataW-1:0] cfg_data_i
);
  import ipfr_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_e  cmd;
  dp_stat_t stat;

  // sequencer: walks release, evict, search, hole update and emit
  ipfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: slot table, hole memory and result register
  ipfr_dp #(
    .SLOTS       (SLOTS),
    .HOLES       (HOLES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: hw/rtl/ipfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_ctrl: sequencer of the fragment reassembly tracker
// steps one request through release, eviction, search, hole walk and result
// ----------------------------------------------------------------------------
module ipfr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ipfr_pkg::dp_stat_t stat_i,
  output ipfr_pkg::dp_cmd_e  cmd_o
);
  import ipfr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:       if (in_valid_i) state_d = S_RELEASE;
      S_RELEASE:    state_d = S_CHECK;
      S_CHECK:      state_d = stat_i.early_exit ? S_FINISH : S_EVICT;
      S_EVICT:      if (!stat_i.evict_need) state_d = S_SEARCH;
      S_SEARCH: begin
        if (stat_i.search_end) begin
          state_d = S_ALLOC;
        end else if (stat_i.search_match) begin
          state_d = S_HOLE_READ;
        end
      end
      S_ALLOC:      state_d = stat_i.no_free ? S_FINISH : S_HOLE_READ;
      S_HOLE_READ:  state_d = stat_i.hole_more ? S_HOLE_PROC : S_COMMIT;
      S_HOLE_PROC:  state_d = stat_i.hole_split ? S_HOLE_SPLIT : S_HOLE_READ;
      S_HOLE_SPLIT: state_d = S_HOLE_READ;
      S_COMMIT:     state_d = S_FINISH;
      S_FINISH:     if (!stat_i.out_busy) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LOAD;
      end
      S_RELEASE:    cmd_o = CMD_RELEASE;
      S_CHECK:      cmd_o = CMD_CHECK;
      S_EVICT:      if (stat_i.evict_need) cmd_o = CMD_EVICT;
      S_SEARCH:     if (!stat_i.search_end) cmd_o = CMD_SEARCH;
      S_ALLOC:      cmd_o = CMD_ALLOC;
      S_HOLE_READ:  if (stat_i.hole_more) cmd_o = CMD_HOLE_READ;
      S_HOLE_PROC:  cmd_o = CMD_HOLE_PROC;
      S_HOLE_SPLIT: cmd_o = CMD_HOLE_SPLIT;
      S_COMMIT:     cmd_o = CMD_COMMIT;
      S_FINISH:     if (!stat_i.out_busy) cmd_o = CMD_EMIT;
      default:      cmd_o = CMD_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/ipfr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_dp: datapath of the fragment reassembly tracker
// slot table, double-banked hole memory, config registers and result register
// ----------------------------------------------------------------------------
module ipfr_dp #(
  parameter int unsigned SLOTS       = ipfr_pkg::SlotsDef,
  parameter int unsigned HOLES       = ipfr_pkg::HolesDef,
  parameter int unsigned MAX_PAYLOAD = ipfr_pkg::MaxPayloadDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ipfr_pkg::dp_cmd_e              cmd_i,
  output ipfr_pkg::dp_stat_t             stat_o,
  input  ipfr_pkg::frag_req_t            in_req_i,
  input  logic                           cfg_we_i,
  input  logic [ipfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipfr_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ipfr_pkg::frag_rsp_t            out_rsp_o
);
  import ipfr_pkg::*;

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned HW    = $clog2(HOLES);
  localparam int unsigned NW    = $clog2(HOLES + 1);
  localparam int unsigned MW    = $clog2(HOLES + 2);
  localparam int unsigned LimW  = CW + 4;
  localparam int unsigned AW    = SW + 1 + HW;
  localparam int unsigned Depth = 1 << AW;

  // configuration
  logic [31:0] max_age_q;
  logic [3:0]  slots_cfg_q;

  // slot table
  logic [SLOTS-1:0] valid_q;
  logic [SW-1:0]    rank_q  [SLOTS];
  logic [31:0]      src_q   [SLOTS];
  logic [31:0]      dst_q   [SLOTS];
  logic [15:0]      ident_q [SLOTS];
  logic [7:0]       proto_q [SLOTS];
  logic [47:0]      time_q  [SLOTS];
  logic [SizeW-1:0] size_q  [SLOTS];
  logic [NW-1:0]    count_q [SLOTS];
  logic [SLOTS-1:0] bank_q;

  logic          rel_pend_q;
  logic [SW-1:0] rel_slot_q;

  // per-request working registers
  frag_req_t     in_q;
  logic [CW-1:0] k_q;
  logic [SW-1:0] s_q;
  logic [NW-1:0] i_q;
  logic [MW-1:0] m_q;
  logic          stop_q;
  logic          ovf_q;
  logic [PosW-1:0] pend_q;
  frag_status_e  res_kind_q;

  logic [2*PosW-1:0] hole_mem [Depth];
  logic [2*PosW-1:0] rd_q;

  logic      out_valid_q;
  frag_rsp_t out_q;

  // header arithmetic
  logic [15:0]     len;
  logic [15:0]     fs;
  logic [PosW-1:0] fs_p, fe_p;
  logic            is_short, is_unfrag, is_over;

  assign len       = in_q.total_length - HdrBytes;
  assign fs        = {in_q.frag_offset_units, 3'b000};
  assign fs_p      = PosW'(fs);
  assign fe_p      = fs_p + PosW'(len);
  assign is_short  = in_q.total_length < HdrBytes;
  assign is_unfrag = !in_q.more_fragments && (in_q.frag_offset_units == '0);
  assign is_over   = fe_p > PosW'(MAX_PAYLOAD);

  // occupancy and slot lookups
  logic [CW-1:0]   cnt;
  logic [LimW-1:0] lim;
  logic            cur_hit;
  logic [SW-1:0]   cur_idx;
  logic            no_free;
  logic [SW-1:0]   free_idx;

  always_comb begin
    cnt = '0;
    for (int j = 0; j < SLOTS; j++) begin
      cnt = cnt + CW'(valid_q[j]);
    end
  end

  always_comb begin
    if (slots_cfg_q == '0) begin
      lim = LimW'(1);
    end else if (LimW'(slots_cfg_q) > LimW'(SLOTS)) begin
      lim = LimW'(SLOTS);
    end else begin
      lim = LimW'(slots_cfg_q);
    end
  end

  always_comb begin
    cur_hit  = 1'b0;
    cur_idx  = '0;
    no_free  = 1'b1;
    free_idx = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (valid_q[j] && (CW'(rank_q[j]) == k_q)) begin
        cur_hit = 1'b1;
        cur_idx = SW'(j);
      end
      if (!valid_q[j]) begin
        no_free  = 1'b0;
        free_idx = SW'(j);
      end
    end
  end

  logic [47:0] age;
  logic        expired, key_match;

  assign age       = in_q.arrival_usec - time_q[cur_idx];
  assign expired   = (in_q.arrival_usec >= time_q[cur_idx]) && (age > {16'd0, max_age_q});
  assign key_match = (src_q[cur_idx] == in_q.source_addr) &&
                     (dst_q[cur_idx] == in_q.dest_addr) &&
                     (ident_q[cur_idx] == in_q.ident) &&
                     (proto_q[cur_idx] == in_q.proto);

  // drop of one slot per cycle: release, eviction or expiry
  logic          drop_en;
  logic [SW-1:0] drop_idx;

  always_comb begin
    drop_en  = 1'b0;
    drop_idx = cur_idx;
    case (cmd_i)
      CMD_RELEASE: begin
        drop_en  = rel_pend_q && valid_q[rel_slot_q];
        drop_idx = rel_slot_q;
      end
      CMD_EVICT:  drop_en = cur_hit;
      CMD_SEARCH: drop_en = cur_hit && expired;
      default:    drop_en = 1'b0;
    endcase
  end

  // one hole against the fragment
  logic [PosW-1:0] ha, hb, hp_ws, hp_we;
  logic            hp_last, hp_wr, hp_split, hp_stop, m_room;

  assign ha      = rd_q[2*PosW-1:PosW];
  assign hp_last = ({1'b0, i_q} + 1'b1) == {1'b0, count_q[s_q]};
  assign hb      = (!in_q.more_fragments && hp_last) ? fe_p : rd_q[PosW-1:0];
  assign m_room  = m_q < MW'(HOLES);

  always_comb begin
    hp_wr    = 1'b1;
    hp_split = 1'b0;
    hp_stop  = stop_q;
    hp_ws    = ha;
    hp_we    = hb;
    if (stop_q || ha >= fe_p) begin
      hp_stop = 1'b1;
    end else if (ha >= fs_p && hb <= fe_p) begin
      hp_wr = 1'b0;
    end else if (ha < fs_p && hb > fe_p) begin
      if (fs_p != fe_p) begin
        hp_we    = fs_p;
        hp_split = 1'b1;
        hp_stop  = 1'b1;
      end
    end else if (ha < fs_p && hb > fs_p) begin
      hp_we = fs_p;
    end else if (ha < fe_p && hb > fe_p) begin
      hp_ws = fe_p;
    end
  end

  // hole memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [2*PosW-1:0] mem_wdata;

  assign mem_raddr = {s_q, bank_q[s_q], i_q[HW-1:0]};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {s_q, ~bank_q[s_q], m_q[HW-1:0]};
    mem_wdata = {hp_ws, hp_we};
    case (cmd_i)
      CMD_ALLOC: begin
        mem_we    = !no_free;
        mem_waddr = {free_idx, 1'b0, {HW{1'b0}}};
        mem_wdata = {{PosW{1'b0}}, PosW'(MAX_PAYLOAD)};
      end
      CMD_HOLE_PROC:  mem_we = hp_wr && m_room;
      CMD_HOLE_SPLIT: begin
        mem_we    = m_room;
        mem_wdata = {fe_p, pend_q};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hole_mem[mem_waddr] <= mem_wdata;
    if (cmd_i == CMD_HOLE_READ) rd_q <= hole_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q   <= MaxAgeRst;
      slots_cfg_q <= SlotsInUseRst;
      valid_q     <= '0;
      rel_pend_q  <= 1'b0;
      rel_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_AGE:      max_age_q   <= cfg_data_i;
          CFG_SLOTS_IN_USE: slots_cfg_q <= cfg_data_i[3:0];
          default:          max_age_q   <= max_age_q;
        endcase
      end
      if (drop_en) valid_q[drop_idx] <= 1'b0;
      if (cmd_i == CMD_ALLOC && !no_free) valid_q[free_idx] <= 1'b1;
      if (cmd_i == CMD_RELEASE) rel_pend_q <= 1'b0;
      if (cmd_i == CMD_COMMIT && !ovf_q && m_q == '0) begin
        rel_pend_q <= 1'b1;
        rel_slot_q <= s_q;
      end
      if (cmd_i == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result for the current request
  frag_rsp_t rsp_d;

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = res_kind_q;
    case (res_kind_q)
      ST_UNFRAG: begin
        rsp_d.place_length = len;
        rsp_d.total_size   = {1'b0, len};
      end
      ST_PENDING, ST_COMPLETE: begin
        rsp_d.slot         = 3'(s_q);
        rsp_d.place_offset = fs;
        rsp_d.place_length = len;
        if (res_kind_q == ST_COMPLETE) rsp_d.total_size = size_q[s_q];
      end
      default: rsp_d = '0;
    endcase
    rsp_d.status = res_kind_q;
  end

  // payload state
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        in_q   <= in_req_i;
        k_q    <= '0;
        i_q    <= '0;
        m_q    <= '0;
        stop_q <= 1'b0;
        ovf_q  <= 1'b0;
      end
      CMD_CHECK: begin
        if (is_short || (!is_unfrag && is_over)) begin
          res_kind_q <= ST_REJECT;
        end else if (is_unfrag) begin
          res_kind_q <= ST_UNFRAG;
        end
      end
      CMD_SEARCH: begin
        if (!expired && key_match) begin
          s_q <= cur_idx;
        end else if (!expired) begin
          k_q <= k_q + 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (no_free) begin
          res_kind_q <= ST_REJECT;
        end else begin
          rank_q[free_idx]  <= SW'(cnt);
          src_q[free_idx]   <= in_q.source_addr;
          dst_q[free_idx]   <= in_q.dest_addr;
          ident_q[free_idx] <= in_q.ident;
          proto_q[free_idx] <= in_q.proto;
          time_q[free_idx]  <= in_q.arrival_usec;
          size_q[free_idx]  <= SizeW'(MAX_PAYLOAD);
          count_q[free_idx] <= NW'(1);
          bank_q[free_idx]  <= 1'b0;
          s_q               <= free_idx;
        end
      end
      CMD_HOLE_PROC: begin
        i_q    <= i_q + 1'b1;
        stop_q <= hp_stop;
        pend_q <= hb;
        if (hp_wr) begin
          m_q <= m_q + 1'b1;
          if (!m_room) ovf_q <= 1'b1;
        end
      end
      CMD_HOLE_SPLIT: begin
        m_q <= m_q + 1'b1;
        if (!m_room) ovf_q <= 1'b1;
      end
      CMD_COMMIT: begin
        if (ovf_q) begin
          res_kind_q <= ST_REJECT;
        end else begin
          count_q[s_q] <= NW'(m_q);
          bank_q[s_q]  <= ~bank_q[s_q];
          if (!in_q.more_fragments) size_q[s_q] <= SizeW'(fe_p);
          res_kind_q <= (m_q == '0) ? ST_COMPLETE : ST_PENDING;
        end
      end
      CMD_EMIT: out_q <= rsp_d;
      default: ;
    endcase
    if (drop_en) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (valid_q[j] && rank_q[j] > rank_q[drop_idx]) rank_q[j] <= rank_q[j] - 1'b1;
      end
    end
  end

  assign stat_o.early_exit   = is_short || is_unfrag || is_over;
  assign stat_o.evict_need   = (LimW'(cnt) >= lim) && cur_hit;
  assign stat_o.search_end   = (k_q >= cnt) || !cur_hit;
  assign stat_o.search_match = cur_hit && !expired && key_match;
  assign stat_o.no_free      = no_free;
  assign stat_o.hole_more    = i_q < count_q[s_q];
  assign stat_o.hole_split   = hp_split;
  assign stat_o.out_busy     = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: tb/sv/ip_fragment_reassembly_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_tracker_tb: self-checking bench for the tracker
// drives directed and random fragment streams through several register
// settings, predicts every response in a scoreboard and checks it in order
// ----------------------------------------------------------------------------
module ip_fragment_reassembly_tracker_tb;
  import ipfr_pkg::*;

  localparam int unsigned NSLOT   = 8;
  localparam int unsigned NHOLE   = 8;
  localparam int unsigned MAXPL   = 65536;
  localparam int unsigned LIMIT   = 900000;
  localparam int unsigned DRAIN   = 80;  // settle time after the last response is back

  // --------------------------------------------------------------------------
  // scoreboard: its own copy of the slot table and hole lists
  // --------------------------------------------------------------------------
  class frag_scoreboard;
    bit [31:0]   max_age;
    bit [3:0]    slot_limit;
    bit          valid[NSLOT];
    int unsigned rank[NSLOT];
    bit [31:0]   src[NSLOT];
    bit [31:0]   dst[NSLOT];
    bit [15:0]   idn[NSLOT];
    bit [7:0]    pro[NSLOT];
    bit [47:0]   stamp[NSLOT];
    int unsigned size[NSLOT];
    int unsigned hcnt[NSLOT];
    int unsigned hs[NSLOT][NHOLE];
    int unsigned he[NSLOT][NHOLE];
    bit          rel_pend;
    int unsigned rel_slot;
    frag_rsp_t   expected_q[$];
    int unsigned errors;
    int unsigned seen[4];

    function new();
      max_age    = MaxAgeRst;
      slot_limit = SlotsInUseRst;
      foreach (valid[i]) valid[i] = 0;
      rel_pend = 0;
      rel_slot = 0;
      errors   = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function int unsigned live_count();
      int unsigned n;
      n = 0;
      foreach (valid[i]) n += valid[i];
      return n;
    endfunction

    function void drop(int unsigned s);
      int unsigned r;
      if (s >= NSLOT || !valid[s]) return;
      r = rank[s];
      valid[s] = 0;
      foreach (valid[i]) if (valid[i] && rank[i] > r) rank[i]--;
    endfunction

    function int unsigned slot_at_rank(int unsigned k);
      foreach (valid[i]) if (valid[i] && rank[i] == k) return i;
      return NSLOT;
    endfunction

    // apply fragment [fs, fe) to the hole list; 0 on hole overflow
    function bit cut_holes(int unsigned s, int unsigned fs, int unsigned fe, bit fin);
      int unsigned ts[NHOLE], te[NHOLE], ns[NHOLE+2], ne[NHOLE+2];
      int unsigned n, m, a, b, sz;
      bit stop;
      n = hcnt[s] > NHOLE ? NHOLE : hcnt[s];
      m = 0;
      sz = size[s];
      stop = 0;
      for (int i = 0; i < n; i++) begin
        ts[i] = hs[s][i];
        te[i] = he[s][i];
      end
      if (fin) begin
        sz = fe;
        if (n > 0) te[n-1] = fe;
      end
      for (int i = 0; i < n; i++) begin
        a = ts[i];
        b = te[i];
        if (stop || a >= fe) begin
          stop = 1;
        end else if (a >= fs && b <= fe) begin
          continue;
        end else if (a < fs && b > fe) begin
          if (fs != fe) begin
            ns[m] = a;
            ne[m] = fs;
            m++;
            a = fe;
            stop = 1;
          end
        end else if (a < fs && b > fs) begin
          b = fs;
        end else if (a < fe && b > fe) begin
          a = fe;
        end
        if (m > NHOLE) return 0;
        ns[m] = a;
        ne[m] = b;
        m++;
      end
      if (m > NHOLE) return 0;
      for (int i = 0; i < m; i++) begin
        hs[s][i] = ns[i];
        he[s][i] = ne[i];
      end
      hcnt[s] = m;
      size[s] = sz & 17'h1ffff;
      return 1;
    endfunction

    function frag_rsp_t placement(frag_req_t q);
      frag_rsp_t   r;
      int unsigned len, fs, fe, lim, k, s, c;
      longint unsigned now;
      r = '0;
      r.status = ST_REJECT;
      if (rel_pend) drop(rel_slot);
      rel_pend = 0;
      if (q.total_length < HdrBytes) return r;
      now = q.arrival_usec;
      len = q.total_length - HdrBytes;
      fs  = q.frag_offset_units * 8;
      fe  = fs + len;
      if (!q.more_fragments && q.frag_offset_units == 0) begin
        r.status = ST_UNFRAG;
        r.place_length = 16'(len);
        r.total_size = 17'(len);
        return r;
      end
      if (fe > MAXPL) return r;
      lim = slot_limit;
      if (lim < 1) lim = 1;
      if (lim > NSLOT) lim = NSLOT;
      while (live_count() >= lim) begin
        s = slot_at_rank(0);
        if (s >= NSLOT) break;
        drop(s);
      end
      // oldest-first search, expired slots are dropped on the way
      k = 0;
      s = NSLOT;
      while (k < live_count()) begin
        c = slot_at_rank(k);
        if (c >= NSLOT) break;
        if (now >= stamp[c] && now - stamp[c] > longint'(max_age)) begin
          drop(c);
        end else if (src[c] == q.source_addr && dst[c] == q.dest_addr &&
                     idn[c] == q.ident && pro[c] == q.proto) begin
          s = c;
          break;
        end else begin
          k++;
        end
      end
      if (s >= NSLOT) begin
        k = live_count();
        for (s = 0; s < NSLOT; s++) if (!valid[s]) break;
        if (s >= NSLOT) return r;
        valid[s] = 1;
        rank[s]  = k;
        src[s]   = q.source_addr;
        dst[s]   = q.dest_addr;
        idn[s]   = q.ident;
        pro[s]   = q.proto;
        stamp[s] = q.arrival_usec;
        size[s]  = MAXPL & 17'h1ffff;
        hcnt[s]  = 1;
        hs[s][0] = 0;
        he[s][0] = MAXPL;
      end
      if (!cut_holes(s, fs, fe, !q.more_fragments)) return r;
      r.slot = 3'(s);
      r.place_offset = 16'(fs);
      r.place_length = 16'(len);
      if (hcnt[s] == 0) begin
        r.status = ST_COMPLETE;
        r.total_size = 17'(size[s]);
        rel_pend = 1;
        rel_slot = s;
      end else begin
        r.status = ST_PENDING;
      end
      return r;
    endfunction

    function void note_request(frag_req_t q);
      expected_q.push_back(placement(q));
    endfunction

    function void check_response(frag_rsp_t got);
      frag_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp_rsp = expected_q[0];
      expected_q.delete(0);
      seen[exp_rsp.status]++;
      if (got.status !== exp_rsp.status) begin
        $error("status: expected %0d actual %0d", exp_rsp.status, got.status);
        errors++;
      end
      if (got.slot !== exp_rsp.slot) begin
        $error("slot: expected %0d actual %0d", exp_rsp.slot, got.slot);
        errors++;
      end
      if (got.place_offset !== exp_rsp.place_offset) begin
        $error("place_offset: expected %0d actual %0d",
               exp_rsp.place_offset, got.place_offset);
        errors++;
      end
      if (got.place_length !== exp_rsp.place_length) begin
        $error("place_length: expected %0d actual %0d",
               exp_rsp.place_length, got.place_length);
        errors++;
      end
      if (got.total_size !== exp_rsp.total_size) begin
        $error("total_size: expected %0d actual %0d",
               exp_rsp.total_size, got.total_size);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block instance
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  frag_req_t           in_req_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  frag_rsp_t           out_rsp_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  ip_fragment_reassembly_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  frag_scoreboard sb = new();

  bit              idle_on = 1'b1;     // random bursts of idling on both sides
  int unsigned     hold_req = 0;       // long receiver hold-off asked by the sender
  int unsigned     cycles = 0;
  int unsigned     sent = 0;
  longint unsigned now_usec;           // running arrival clock
  bit [31:0]       src_pool[2];
  bit [31:0]       dst_pool[2];
  bit [15:0]       id_pool[3];
  bit [7:0]        pro_pool[2];

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side: check accepted responses, stall in bursts or on request
  always @(posedge clk_i) begin : rsp_side
    int unsigned stall_left;
    int unsigned hold_left;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 19);
      out_ready_i <= (hold_left == 0 && stall_left == 0);
      if (hold_left != 0) hold_left--;
      if (stall_left != 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // request driving
  // --------------------------------------------------------------------------
  task automatic send_request(frag_req_t q);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(q);
    sent++;
  endtask

  // sender pause until every response is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_MAX_AGE) sb.max_age = data;
    else sb.slot_limit = data[3:0];
  endtask

  function automatic frag_req_t make_frag(int unsigned key, bit mf, int unsigned off_units,
                                          int unsigned tl);
    frag_req_t q;
    q.arrival_usec      = now_usec[47:0];
    q.source_addr       = src_pool[key % 2];
    q.dest_addr         = dst_pool[(key / 2) % 2];
    q.ident             = id_pool[(key / 4) % 3];
    q.proto             = pro_pool[(key / 12) % 2];
    q.more_fragments    = mf;
    q.frag_offset_units = 13'(off_units);
    q.total_length      = 16'(tl);
    return q;
  endfunction

  function automatic frag_req_t noise_req();
    frag_req_t  q;
    bit [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(frag_req_t)-1:0];
    if ($urandom_range(0, 2) == 0) q.total_length = 16'($urandom_range(0, 300));
    if ($urandom_range(0, 3) == 0) q.frag_offset_units = 13'($urandom_range(0, 40));
    return q;
  endfunction

  task automatic advance_clock();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) now_usec += $urandom_range(0, 3) * longint'(sb.max_age) + $urandom;
    else if (pick < 6) now_usec -= $urandom_range(1, 200);  // time going back
    else now_usec += $urandom_range(0, 30);
    now_usec &= 48'hffff_ffff_ffff;
  endtask

  // one datagram cut into fragments, sent in shuffled order with a chance of
  // a duplicate, overlap or missing piece
  task automatic send_datagram();
    int unsigned key, nfrag, pos;
    int unsigned offs[$], tls[$], order[$];
    bit          mfs[$];
    key   = $urandom_range(0, 23);
    nfrag = $urandom_range(1, 6);
    pos   = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8100) : 0;
    for (int i = 0; i < nfrag; i++) begin
      int unsigned units;
      units = $urandom_range(1, 20);
      offs.push_back(pos);
      if (i == nfrag - 1) begin
        tls.push_back(20 + $urandom_range(0, 160));
        mfs.push_back($urandom_range(0, 7) == 0);
      end else begin
        tls.push_back(20 + units * 8);
        mfs.push_back(1'b1);
      end
      pos += units;
      order.push_back(i);
    end
    order.shuffle();
    if ($urandom_range(0, 5) == 0) order.push_back(order[0]);
    if ($urandom_range(0, 7) == 0) order.delete(0);
    foreach (order[j]) begin
      int unsigned o, tl;
      o  = offs[order[j]];
      tl = tls[order[j]];
      if ($urandom_range(0, 11) == 0) tl += $urandom_range(1, 40);  // overlap
      if (o > 8191) o = 8191;
      advance_clock();
      send_request(make_frag(key, mfs[order[j]], o, tl));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    bit [31:0] ages[6];
    bit [3:0]  limits[6];
    int unsigned per_phase;
    now_usec = {$urandom, $urandom} & 48'hffff_ffff_ffff;
    foreach (src_pool[i]) src_pool[i] = $urandom;
    foreach (dst_pool[i]) dst_pool[i] = $urandom;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    foreach (pro_pool[i]) pro_pool[i] = 8'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short headers, unfragmented extremes, oversized fragment
    send_request(make_frag(0, 1'b0, 0, 0));
    send_request(make_frag(0, 1'b1, 3, 19));
    send_request(make_frag(0, 1'b0, 0, 20));
    send_request(make_frag(0, 1'b0, 0, 65535));
    send_request(make_frag(0, 1'b1, 8191, 100));
    // two-piece datagram, final first, then a late duplicate
    send_request(make_frag(1, 1'b0, 2, 36));
    send_request(make_frag(1, 1'b1, 0, 36));
    send_request(make_frag(1, 1'b0, 2, 36));
    // empty final fragment and an inverted last hole
    send_request(make_frag(2, 1'b1, 4, 52));
    send_request(make_frag(2, 1'b0, 1, 20));
    // no final fragment: holes empty at the full payload size
    send_request(make_frag(3, 1'b1, 0, 65535));
    send_request(make_frag(3, 1'b1, 8189, 44));
    // hole overflow: isolated small pieces split the hole repeatedly
    for (int i = 0; i < 9; i++) send_request(make_frag(4, 1'b1, 2 + 3 * i, 28));
    send_request(make_frag(4, 1'b1, 8191, 20));
    // expiry with a max age of 1
    drain();
    write_reg(CFG_MAX_AGE, 32'd1);
    send_request(make_frag(5, 1'b1, 0, 28));
    now_usec += 2;
    send_request(make_frag(5, 1'b0, 1, 28));

    // random phases through register extremes; slot limits 0 and 15 clamp
    ages   = '{MaxAgeRst, 32'd1, 32'hffff_ffff, 32'd60, $urandom, 32'd500};
    limits = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5};
    per_phase = 1150 / 6;
    foreach (ages[p]) begin
      int unsigned start;
      drain();
      write_reg(CFG_MAX_AGE, ages[p]);
      write_reg(CFG_SLOTS_IN_USE, {28'd0, limits[p]});
      if (p == 2) hold_req = 600;  // receiver holds off, the block backs up
      if (p == 5) idle_on = 1'b0;
      start = sent;
      while (sent - start < per_phase) begin
        if ($urandom_range(0, 6) == 0) begin
          advance_clock();
          send_request(noise_req());
        end else begin
          send_datagram();
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (DRAIN) @(posedge clk_i);
    $display("requests sent: %0d over 7 register settings", sent);
    $display("responses: unfragmented %0d pending %0d complete %0d rejected %0d",
             sb.seen[ST_UNFRAG], sb.seen[ST_PENDING], sb.seen[ST_COMPLETE],
             sb.seen[ST_REJECT]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
